[rtl/core/assert_macros.svh]
// Assertion helpers used by rfgd_rx_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/core/rfgd_pkg.sv]
// ----------------------------------------------------------------------------
// rfgd_pkg
// Types and codes shared by the frame-gap deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package rfgd_pkg;

  localparam int OP_W        = 2;
  localparam int BYTE_W      = 8;
  localparam int TIME_W      = 16;
  localparam int INDEX_W     = 8;
  localparam int LEN_W       = 9;
  localparam int ERR_W       = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_INTER_FRAME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTER_CHAR  = 2'd1;

  localparam logic [TIME_W-1:0] INTER_FRAME_RESET = 16'd1950;
  localparam logic [TIME_W-1:0] INTER_CHAR_RESET  = 16'd850;

  typedef struct packed {
    logic             frame_ready;
    logic [LEN_W-1:0] frame_length;
    logic [ERR_W-1:0] frame_errors;
    logic             receiving;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/rfgd_if.sv]
// ----------------------------------------------------------------------------
// rfgd_if
// Valid/ready channels of the frame-gap deframer: items, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfgd_item_if;
  logic                         valid;
  logic                         ready;
  logic [rfgd_pkg::OP_W-1:0]    op;
  logic [rfgd_pkg::BYTE_W-1:0]  rx_byte;
  logic [rfgd_pkg::TIME_W-1:0]  time_us;
  logic [rfgd_pkg::INDEX_W-1:0] read_index;

  modport source (output valid, op, rx_byte, time_us, read_index, input ready);
  modport sink (input valid, op, rx_byte, time_us, read_index, output ready);
endinterface

interface rfgd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_ready;
  logic [rfgd_pkg::LEN_W-1:0]  frame_length;
  logic [rfgd_pkg::BYTE_W-1:0] read_byte;
  logic [rfgd_pkg::ERR_W-1:0]  frame_errors;
  logic                        receiving;

  modport source (output valid, frame_ready, frame_length, read_byte, frame_errors,
                  receiving, input ready);
  modport sink (input valid, frame_ready, frame_length, read_byte, frame_errors,
                receiving, output ready);
endinterface

interface rfgd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rfgd_pkg::CFG_INDEX_W-1:0] index;
  logic [rfgd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/rfgd_rx_ctrl.sv]
// ----------------------------------------------------------------------------
// rfgd_rx_ctrl
// Receive state: frame timing, fill count, error count and buffer writes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfgd_rx_ctrl #(
  parameter int FRAME_DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    accept,
  input  wire logic [rfgd_pkg::OP_W-1:0]               op,
  input  wire logic [rfgd_pkg::TIME_W-1:0]             time_us,
  input  wire logic [rfgd_pkg::TIME_W-1:0]             inter_frame_gap_us,
  input  wire logic [rfgd_pkg::TIME_W-1:0]             inter_char_gap_us,
  output rfgd_pkg::res_t                               res,
  output logic                                         wr_en,
  output logic [$clog2(FRAME_DEPTH)-1:0]               wr_addr
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic                           receiving;
  logic                           receiving_next;
  logic [CW-1:0]                  fill_count;
  logic [CW-1:0]                  fill_count_next;
  logic [rfgd_pkg::TIME_W-1:0]    last_byte_time;
  logic [rfgd_pkg::TIME_W-1:0]    last_byte_time_next;
  logic [rfgd_pkg::ERR_W-1:0]     error_count;
  logic [rfgd_pkg::ERR_W-1:0]     error_count_next;

  logic [rfgd_pkg::TIME_W-1:0]    gap;
  logic                           gap_frame;
  logic                           gap_char;
  logic [CW-1:0]                  base;
  logic                           room;

  assign gap       = time_us - last_byte_time;
  assign gap_frame = gap >= inter_frame_gap_us;
  assign gap_char  = gap > inter_char_gap_us;
  assign base      = (!receiving || gap_frame || gap_char) ? '0 : fill_count;
  assign room      = base < CW'(FRAME_DEPTH);

  always_comb begin
    receiving_next      = receiving;
    fill_count_next     = fill_count;
    last_byte_time_next = last_byte_time;
    error_count_next    = error_count;
    res.frame_ready     = 1'b0;
    res.frame_length    = '0;
    wr_en               = 1'b0;
    wr_addr             = AW'(base);
    unique case (op)
      rfgd_pkg::OP_BYTE: begin
        if (receiving && !gap_frame && gap_char) begin
          error_count_next = error_count + rfgd_pkg::ERR_W'(1);
        end
        if (room) begin
          wr_en           = accept;
          fill_count_next = base + CW'(1);
        end else begin
          fill_count_next = base;
        end
        receiving_next      = 1'b1;
        last_byte_time_next = time_us;
      end
      rfgd_pkg::OP_TICK: begin
        if (receiving && (fill_count != '0) && gap_frame) begin
          res.frame_ready  = 1'b1;
          res.frame_length = rfgd_pkg::LEN_W'(fill_count);
          fill_count_next  = '0;
          receiving_next   = 1'b0;
        end
      end
      rfgd_pkg::OP_READ: begin
      end
      rfgd_pkg::OP_CLEAR: begin
        receiving_next  = 1'b0;
        fill_count_next = '0;
      end
      default: begin
      end
    endcase
    res.frame_errors = error_count_next;
    res.receiving    = receiving_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving      <= 1'b0;
      fill_count     <= '0;
      last_byte_time <= '0;
      error_count    <= '0;
    end else if (accept) begin
      receiving      <= receiving_next;
      fill_count     <= fill_count_next;
      last_byte_time <= last_byte_time_next;
      error_count    <= error_count_next;
    end
  end

  `ASSERT_IMPL(a_idle_empty, clk, rst, !receiving, fill_count == '0, "fill count set while idle")
  `ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill_count <= CW'(FRAME_DEPTH), "fill count past depth")
  `ASSERT_NEXT(a_hold_state, clk, rst, !accept,
               $stable(fill_count) && $stable(error_count), "state moved without item")

endmodule

`default_nettype wire

[rtl/core/rtu_frame_gap_deframer_unit.sv]
// ----------------------------------------------------------------------------
// rtu_frame_gap_deframer_unit
// Frame-gap deframer: splits timestamped serial bytes into frames by silence.
// ----------------------------------------------------------------------------
// One item enters per cycle while result_out accepts results: the item
// updates the receive state and reads the frame buffer at the accept edge,
// then the result passes through a pipeline register and an output register.
// The buffer is a single-write, single-read memory of FRAME_DEPTH bytes with
// registered read data; stored bytes stay readable until overwritten, and
// entries never written since reset read back as unknown data.
`default_nettype none

module rtu_frame_gap_deframer_unit #(
  parameter int FRAME_DEPTH = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rfgd_item_if.sink     item_in,
  rfgd_result_if.source result_out,
  rfgd_cfg_if.sink      cfg
);

  localparam int AW = $clog2(FRAME_DEPTH);

  logic [rfgd_pkg::TIME_W-1:0] inter_frame_gap_us;
  logic [rfgd_pkg::TIME_W-1:0] inter_char_gap_us;

  logic                        accept;
  logic                        p_valid;
  logic                        p_advance;
  rfgd_pkg::res_t              p_res;
  logic                        p_is_read;
  rfgd_pkg::res_t              res;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic                        rd_in_range;
  logic [rfgd_pkg::BYTE_W-1:0] rd_q;
  logic [rfgd_pkg::BYTE_W-1:0] mem [FRAME_DEPTH];

  logic                        o_valid;
  rfgd_pkg::res_t              o_res;
  logic [rfgd_pkg::BYTE_W-1:0] o_read_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inter_frame_gap_us <= rfgd_pkg::INTER_FRAME_RESET;
      inter_char_gap_us  <= rfgd_pkg::INTER_CHAR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rfgd_pkg::CFG_INTER_FRAME: inter_frame_gap_us <= cfg.data;
        rfgd_pkg::CFG_INTER_CHAR:  inter_char_gap_us  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign p_advance     = p_valid && (!o_valid || result_out.ready);
  assign item_in.ready = !p_valid || p_advance;
  assign accept        = item_in.valid && item_in.ready;

  rfgd_rx_ctrl #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_rx_ctrl (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .op                 (item_in.op),
    .time_us            (item_in.time_us),
    .inter_frame_gap_us (inter_frame_gap_us),
    .inter_char_gap_us  (inter_char_gap_us),
    .res                (res),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr)
  );

  assign rd_addr     = AW'(item_in.read_index);
  assign rd_in_range = 32'(item_in.read_index) < 32'(FRAME_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_in.rx_byte;
    end
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_advance) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res     <= res;
      p_is_read <= (item_in.op == rfgd_pkg::OP_READ) && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_advance) begin
      o_valid <= 1'b1;
    end else if (result_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_advance) begin
      o_res       <= p_res;
      o_read_byte <= p_is_read ? rd_q : '0;
    end
  end

  assign result_out.valid        = o_valid;
  assign result_out.frame_ready  = o_res.frame_ready;
  assign result_out.frame_length = o_res.frame_length;
  assign result_out.read_byte    = o_read_byte;
  assign result_out.frame_errors = o_res.frame_errors;
  assign result_out.receiving    = o_res.receiving;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the RTU frame-gap deframer unit. Timestamped bytes,
// ticks, buffer reads and receiver resets are planned into a queue and sent
// over the item channel with random gaps; results are checked against an
// in-bench model of the frame timing, through several gap-limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfgd_pkg::*;

  localparam int FRAME_DEPTH   = 256;
  localparam int LIVE          = 0;
  localparam int PLAN          = 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  rx_byte;
    logic [TIME_W-1:0]  time_us;
    logic [INDEX_W-1:0] read_index;
  } deframe_item_t;

  typedef struct packed {
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_byte;
    logic [ERR_W-1:0]  frame_errors;
    logic              receiving;
  } deframe_res_t;

  logic clk;
  logic rst;

  rfgd_item_if   item_in();
  rfgd_result_if result_out();
  rfgd_cfg_if    cfg();

  rtu_frame_gap_deframer_unit #(.FRAME_DEPTH(FRAME_DEPTH)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  // two copies of the receiver state: one follows accepted beats, one the plan
  logic [TIME_W-1:0] gap_frame [2];
  logic [TIME_W-1:0] gap_char [2];
  logic              rx_active [2];
  int                fill_cnt [2];
  logic [TIME_W-1:0] last_stamp [2];
  logic [ERR_W-1:0]  err_total [2];
  logic [BYTE_W-1:0] store_mem [2][FRAME_DEPTH];
  bit                written_mem [2][FRAME_DEPTH];

  deframe_item_t serial_items [$];
  deframe_res_t  deframe_due [$];
  deframe_item_t cur_item;
  logic [TIME_W-1:0] now;

  int unsigned items_offered;
  int unsigned items_taken;
  int unsigned results_taken;
  int unsigned results_seen;
  int unsigned planned;
  int unsigned fault_count;
  int unsigned idle_cycles;
  int unsigned send_wait;
  int unsigned recv_wait;
  bit offering;
  bit send_burst;
  bit recv_burst;
  bit rx_hold;

  function automatic deframe_res_t deframe_step(input int c, input deframe_item_t it);
    deframe_res_t r;
    logic [TIME_W-1:0] gap;
    r = '0;
    gap = it.time_us - last_stamp[c];
    case (it.op)
      OP_BYTE: begin
        if (!rx_active[c]) begin
          fill_cnt[c] = 0;
          rx_active[c] = 1'b1;
        end else if (gap >= gap_frame[c]) begin
          fill_cnt[c] = 0;
        end else if (gap > gap_char[c]) begin
          err_total[c] = err_total[c] + 1;
          fill_cnt[c] = 0;
        end
        if (fill_cnt[c] < FRAME_DEPTH) begin
          store_mem[c][fill_cnt[c]] = it.rx_byte;
          written_mem[c][fill_cnt[c]] = 1'b1;
          fill_cnt[c] = fill_cnt[c] + 1;
        end
        last_stamp[c] = it.time_us;
      end
      OP_TICK: begin
        if (rx_active[c] && fill_cnt[c] != 0 && gap >= gap_frame[c]) begin
          r.frame_ready = 1'b1;
          r.frame_length = fill_cnt[c][LEN_W-1:0];
          fill_cnt[c] = 0;
          rx_active[c] = 1'b0;
        end
      end
      OP_READ: begin
        if (int'(it.read_index) < FRAME_DEPTH) r.read_byte = store_mem[c][it.read_index];
      end
      default: begin
        rx_active[c] = 1'b0;
        fill_cnt[c] = 0;
      end
    endcase
    r.frame_errors = err_total[c];
    r.receiving = rx_active[c];
    return r;
  endfunction

  function automatic void reset_model(input int c);
    gap_frame[c] = INTER_FRAME_RESET;
    gap_char[c] = INTER_CHAR_RESET;
    rx_active[c] = 1'b0;
    fill_cnt[c] = 0;
    last_stamp[c] = '0;
    err_total[c] = '0;
    for (int k = 0; k < FRAME_DEPTH; k++) begin
      store_mem[c][k] = '0;
      written_mem[c][k] = 1'b0;
    end
  endfunction

  function automatic logic [TIME_W-1:0] pick_within();
    int fr;
    int ch;
    int lim;
    fr = gap_frame[PLAN];
    ch = gap_char[PLAN];
    lim = (ch < fr - 1) ? ch : fr - 1;
    return (lim < 0) ? '0 : TIME_W'($urandom_range(0, lim));
  endfunction

  function automatic logic [TIME_W-1:0] pick_gap();
    int fr;
    int ch;
    logic [TIME_W-1:0] g;
    fr = gap_frame[PLAN];
    ch = gap_char[PLAN];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: g = pick_within();
      6, 7: g = (ch + 1 < fr) ? TIME_W'($urandom_range(ch + 1, fr - 1)) : TIME_W'($urandom);
      8: g = TIME_W'($urandom_range(fr, 65535));
      default: g = TIME_W'($urandom);
    endcase
    return g;
  endfunction

  function automatic logic [TIME_W-1:0] pick_quiet(input bit long_enough);
    int fr;
    fr = gap_frame[PLAN];
    if (long_enough) return TIME_W'($urandom_range(fr, 65535));
    return (fr == 0) ? '0 : TIME_W'($urandom_range(0, fr - 1));
  endfunction

  task automatic plan_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                           input logic [TIME_W-1:0] t, input logic [INDEX_W-1:0] idx);
    deframe_item_t it;
    deframe_res_t  unused;
    int start;
    it.op = op;
    it.rx_byte = b;
    it.time_us = t;
    it.read_index = idx;
    if (op == OP_READ && !written_mem[PLAN][idx]) begin
      start = $urandom_range(0, FRAME_DEPTH - 1);
      it.op = OP_TICK;
      for (int k = 0; k < FRAME_DEPTH; k++) begin
        if (written_mem[PLAN][(start + k) % FRAME_DEPTH]) begin
          it.op = OP_READ;
          it.read_index = INDEX_W'((start + k) % FRAME_DEPTH);
          break;
        end
      end
    end
    unused = deframe_step(PLAN, it);
    serial_items.push_back(it);
    planned++;
  endtask

  task automatic plan_byte(input logic [TIME_W-1:0] gap);
    now = now + gap;
    plan_item(OP_BYTE, BYTE_W'($urandom), now, INDEX_W'($urandom));
  endtask

  task automatic plan_tick(input logic [TIME_W-1:0] gap);
    now = now + gap;
    plan_item(OP_TICK, BYTE_W'($urandom), now, INDEX_W'($urandom));
  endtask

  task automatic plan_read();
    plan_item(OP_READ, BYTE_W'($urandom), TIME_W'($urandom), INDEX_W'($urandom));
  endtask

  task automatic plan_frame(input int len, input bit steady);
    plan_byte(pick_gap());
    for (int k = 1; k < len; k++) begin
      if (!steady && $urandom_range(0, 9) == 0) plan_read();
      plan_byte((steady || $urandom_range(0, 9) < 8) ? pick_within() : pick_gap());
    end
    plan_tick(pick_quiet(steady || $urandom_range(0, 9) < 7));
    repeat ($urandom_range(0, 3)) plan_read();
  endtask

  task automatic plan_traffic(input int unsigned goal);
    logic [OP_W-1:0] op;
    while (planned < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          plan_frame(($urandom_range(0, 24) == 0) ? $urandom_range(250, 262)
                                                  : $urandom_range(1, 12), 1'b0);
        end
        7, 8: begin
          repeat ($urandom_range(1, 3)) begin
            op = OP_W'($urandom_range(0, 3));
            if (op == OP_BYTE || op == OP_TICK) now = now + pick_gap();
            plan_item(op, BYTE_W'($urandom),
                      (op == OP_BYTE || op == OP_TICK) ? now : TIME_W'($urandom),
                      INDEX_W'($urandom));
          end
        end
        default: begin
          plan_byte(pick_gap());
          repeat ($urandom_range(0, 3)) plan_byte(pick_within());
          if ($urandom_range(0, 1) == 0)
            plan_item(OP_CLEAR, BYTE_W'($urandom), TIME_W'($urandom), INDEX_W'($urandom));
          else
            plan_tick(pick_quiet(1'b0));
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_INTER_FRAME) begin
      gap_frame[LIVE] = val;
      gap_frame[PLAN] = val;
    end else if (idx == CFG_INTER_CHAR) begin
      gap_char[LIVE] = val;
      gap_char[PLAN] = val;
    end
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (serial_items.size() != 0 || items_offered != items_taken || deframe_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] frame_us,
                           input logic [CFG_DATA_W-1:0] char_us, input int unsigned goal);
    drain();
    write_reg(CFG_INTER_FRAME, frame_us);
    write_reg(CFG_INTER_CHAR, char_us);
    @(posedge clk);
    plan_traffic(goal);
  endtask

  task automatic report_fault(input deframe_res_t want, input deframe_res_t got, input bit orphan);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      if (orphan)
        $display("deframer result beat with nothing due: rdy=%0d len=%0d byte=%02h err=%0d rcv=%0d",
                 got.frame_ready, got.frame_length, got.read_byte, got.frame_errors, got.receiving);
      else
        $display("deframer mismatch: want rdy=%0d len=%0d byte=%02h err=%0d rcv=%0d, got rdy=%0d len=%0d byte=%02h err=%0d rcv=%0d",
                 want.frame_ready, want.frame_length, want.read_byte, want.frame_errors,
                 want.receiving, got.frame_ready, got.frame_length, got.read_byte,
                 got.frame_errors, got.receiving);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      item_in.valid <= 1'b0;
      offering = 1'b0;
      send_wait = 0;
    end else begin
      if (offering && items_taken == items_offered) begin
        offering = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 8);
      end
      if (!offering) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (serial_items.size() != 0) begin
          cur_item = serial_items.pop_front();
          offering = 1'b1;
          items_offered++;
        end
      end
      item_in.valid <= offering;
      item_in.op <= cur_item.op;
      item_in.rx_byte <= cur_item.rx_byte;
      item_in.time_us <= cur_item.time_us;
      item_in.read_index <= cur_item.read_index;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= !rx_hold;
      end
    end
  end

  always @(posedge clk) begin
    deframe_item_t it;
    deframe_res_t  got;
    deframe_res_t  want;
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        results_taken++;
        got.frame_ready = result_out.frame_ready;
        got.frame_length = result_out.frame_length;
        got.read_byte = result_out.read_byte;
        got.frame_errors = result_out.frame_errors;
        got.receiving = result_out.receiving;
        if (deframe_due.size() == 0) begin
          report_fault(got, got, 1'b1);
        end else begin
          want = deframe_due.pop_front();
          if (got !== want) report_fault(want, got, 1'b0);
        end
      end
      if (item_in.valid && item_in.ready) begin
        items_taken++;
        it.op = item_in.op;
        it.rx_byte = item_in.rx_byte;
        it.time_us = item_in.time_us;
        it.read_index = item_in.read_index;
        deframe_due.push_back(deframe_step(LIVE, it));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("rtu_frame_gap_deframer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rx_hold = 1'b0;
    @(posedge clk);
    while (!(items_taken >= 400 && serial_items.size() > 64)) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    rst = 1'b1;
    item_in.valid = 1'b0;
    item_in.op = OP_BYTE;
    item_in.rx_byte = '0;
    item_in.time_us = '0;
    item_in.read_index = '0;
    result_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_INTER_FRAME;
    cfg.data = '0;
    cur_item = '0;
    now = '0;
    items_offered = 0;
    items_taken = 0;
    results_taken = 0;
    results_seen = 0;
    planned = 0;
    fault_count = 0;
    idle_cycles = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    reset_model(LIVE);
    reset_model(PLAN);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    plan_item(OP_TICK,  8'h00, 16'd5000,  8'h00);
    plan_item(OP_BYTE,  8'h00, 16'd100,   8'h00);
    plan_item(OP_BYTE,  8'hFF, 16'd950,   8'hFF);
    plan_item(OP_BYTE,  8'hA5, 16'd1801,  8'h00);
    plan_item(OP_BYTE,  8'h5A, 16'd3751,  8'h00);
    plan_item(OP_BYTE,  8'h3C, 16'd3761,  8'h00);
    plan_item(OP_TICK,  8'h00, 16'd5710,  8'h00);
    plan_item(OP_READ,  8'h00, 16'd0,     8'd0);
    plan_item(OP_READ,  8'h00, 16'd0,     8'd1);
    plan_item(OP_TICK,  8'h00, 16'd5711,  8'h00);
    plan_item(OP_TICK,  8'h00, 16'd9000,  8'h00);
    plan_item(OP_BYTE,  8'h81, 16'd65530, 8'h00);
    plan_item(OP_BYTE,  8'h7E, 16'd5,     8'h00);
    plan_item(OP_BYTE,  8'h11, 16'd855,   8'h00);
    plan_item(OP_CLEAR, 8'h00, 16'd900,   8'h00);
    plan_item(OP_READ,  8'h00, 16'd0,     8'd2);
    plan_item(OP_TICK,  8'h00, 16'd60000, 8'h00);
    plan_item(OP_BYTE,  8'h22, 16'd60010, 8'h00);
    plan_item(OP_BYTE,  8'h33, 16'd61010, 8'h00);
    plan_item(OP_TICK,  8'h00, 16'd65535, 8'hFF);
    plan_item(OP_READ,  8'h00, 16'hFFFF,  8'd0);
    now = 16'd65535;

    plan_frame(258, 1'b1);
    repeat (8) plan_read();
    plan_traffic(300);

    run_phase(16'd4210, 16'd1818, 550);
    drain();
    write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
    run_phase(16'd0, 16'd0, 750);
    run_phase(16'd65535, 16'd65535, 950);
    run_phase(16'd65535, 16'd55100, 1150);
    run_phase(16'd12, 16'd5, 1400);
    run_phase(16'd100, 16'd3000, 1550);
    run_phase(16'd1950, 16'd850, 1920);
    drain();

    if (fault_count == 0)
      $display("rtu_frame_gap_deframer_unit regression: pass");
    else
      $display("rtu_frame_gap_deframer_unit regression: fail");
    $finish;
  end

endmodule
